/* sv/msx_pkg.sv */
package msx_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_SPECIAL2 = 6'd28;

  localparam logic [5:0] FN_SLL = 6'd0;
  localparam logic [5:0] FN_SRL = 6'd2;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_SLT = 6'd42;
  localparam logic [5:0] FN_MUL = 6'd2;

  localparam logic [31:0] SYSCALL_WORD = 32'h0000_000C;

  localparam logic [31:0] SYS_PRINT_INT  = 32'd1;
  localparam logic [31:0] SYS_EXIT       = 32'd10;
  localparam logic [31:0] SYS_PRINT_CHAR = 32'd11;

  localparam logic [4:0] REG_V0 = 5'd2;
  localparam logic [4:0] REG_A0 = 5'd4;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_PRINT_INT   = 3'd1,
    EV_PRINT_CHAR  = 3'd2,
    EV_EXIT        = 3'd3,
    EV_BAD_SYSCALL = 3'd4,
    EV_BAD_BRANCH  = 3'd5
  } ev_t;

  typedef struct packed {
    logic        wr;
    logic [4:0]  dst;
    logic [31:0] val;
  } alu_res_t;

endpackage

/* sv/msx_alu.sv */
module msx_alu (
  input  logic [31:0]         instr,
  input  logic [31:0]         vs,
  input  logic [31:0]         vt,
  output msx_pkg::alu_res_t   res
);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [31:0] uimm;
  logic [31:0] simm;

  assign op   = instr[31:26];
  assign fn   = instr[5:0];
  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sh   = instr[10:6];
  assign uimm = {16'h0000, instr[15:0]};
  assign simm = {{16{instr[15]}}, instr[15:0]};

  always_comb begin
    res = '0;
    unique case (op)
      msx_pkg::OP_SPECIAL: begin
        res.dst = rd;
        res.wr  = 1'b1;
        unique case (fn)
          msx_pkg::FN_ADD: res.val = vs + vt;
          msx_pkg::FN_SUB: res.val = vs - vt;
          msx_pkg::FN_AND: res.val = vs & vt;
          msx_pkg::FN_OR:  res.val = vs | vt;
          msx_pkg::FN_SLT: res.val = {31'd0, $signed(vs) < $signed(vt)};
          msx_pkg::FN_SLL: res.val = vt << sh;
          msx_pkg::FN_SRL: res.val = vt >> sh;
          default:         res.wr  = 1'b0;
        endcase
      end
      msx_pkg::OP_SPECIAL2: begin
        res.dst = rd;
        res.wr  = (fn == msx_pkg::FN_MUL);
        res.val = vs * vt;
      end
      msx_pkg::OP_ADDI: begin
        res.wr = 1'b1; res.dst = rt; res.val = vs + simm;
      end
      msx_pkg::OP_SLTI: begin
        res.wr = 1'b1; res.dst = rt; res.val = {31'd0, $signed(vs) < $signed(simm)};
      end
      msx_pkg::OP_ANDI: begin
        res.wr = 1'b1; res.dst = rt; res.val = vs & uimm;
      end
      msx_pkg::OP_ORI: begin
        res.wr = 1'b1; res.dst = rt; res.val = vs | uimm;
      end
      msx_pkg::OP_XORI: begin
        res.wr = 1'b1; res.dst = rt; res.val = vs ^ uimm;
      end
      msx_pkg::OP_LUI: begin
        res.wr = 1'b1; res.dst = rt; res.val = {instr[15:0], 16'h0000};
      end
      default: res = '0;
    endcase
    // no write, or a write to register 0, reports nothing
    if (!res.wr || res.dst == 5'd0) begin
      res = '0;
    end
  end

endmodule

/* sv/mips_subset_execute_step.sv */
// Register read, then execute: out_valid rises once an accepted instruction
// leaves the read stage and executes.
// Throughput: one instruction per cycle unless out_ready stalls; registers are
// read on accept and written on execute; a write-to-read bypass covers back-to-back dependencies.
// Reset: program index goes to zero and all 32 register valid bits clear, so
// every register reads zero until written; no clearing pass, ready right away.
module mips_subset_execute_step #(
  parameter int PROGRAM_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instr_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_next_index,
  output logic [2:0]  out_event_res,
  output logic [31:0] out_event_value,
  output logic        out_write_valid,
  output logic [4:0]  out_write_reg,
  output logic [31:0] out_write_value
);

  localparam int PC_W  = $clog2(PROGRAM_DEPTH + 1);
  localparam int TGT_W = ((PC_W > 16) ? PC_W : 16) + 2;
  localparam logic [PC_W-1:0]  DEPTH_PC  = PC_W'(PROGRAM_DEPTH);
  localparam logic [TGT_W-1:0] DEPTH_TGT = TGT_W'(PROGRAM_DEPTH);

  // register file storage
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;

  logic            in_fire;
  logic            s1_adv;
  logic            s1_valid_r;
  logic [31:0]     s1_instr_r;
  logic [31:0]     rd_a_r, rd_b_r;
  logic            vld_a_r, vld_b_r;
  logic            fwd_a_r, fwd_b_r;
  logic [31:0]     fwd_val_r;
  logic [4:0]      ra, rb;
  logic [PC_W-1:0] pc_r;

  logic [31:0]       vs, vt;
  msx_pkg::alu_res_t alu_res;
  logic              wr_en;
  logic [5:0]        op;
  logic              halted;
  logic              is_br, take;
  logic [TGT_W-1:0]  tgt;
  logic [PC_W-1:0]   pc_nxt;
  msx_pkg::ev_t      ev;
  logic [31:0]       ev_val;

  logic        out_valid_r;
  logic [10:0] out_next_index_r;
  logic [2:0]  out_event_res_r;
  logic [31:0] out_event_value_r;
  logic        out_write_valid_r;
  logic [4:0]  out_write_reg_r;
  logic [31:0] out_write_value_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // syscall reads v0 and a0 through the two read ports
  assign ra = (in_instr_word == msx_pkg::SYSCALL_WORD) ? msx_pkg::REG_V0 : in_instr_word[25:21];
  assign rb = (in_instr_word == msx_pkg::SYSCALL_WORD) ? msx_pkg::REG_A0 : in_instr_word[20:16];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_a_r <= rf_mem[ra];
      rd_b_r <= rf_mem[rb];
    end
    if (wr_en) begin
      rf_mem[alu_res.dst] <= alu_res.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r   <= '0;
      s1_valid_r <= 1'b0;
      pc_r       <= '0;
    end else begin
      if (wr_en) begin
        rf_vld_r[alu_res.dst] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        pc_r <= pc_nxt;
      end
    end
  end

  // read-side metadata; bypass covers a write landing on the read edge
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_instr_word;
      vld_a_r    <= rf_vld_r[ra];
      vld_b_r    <= rf_vld_r[rb];
      fwd_a_r    <= wr_en && (alu_res.dst == ra);
      fwd_b_r    <= wr_en && (alu_res.dst == rb);
      fwd_val_r  <= alu_res.val;
    end
  end

  assign vs = fwd_a_r ? fwd_val_r : (vld_a_r ? rd_a_r : 32'd0);
  assign vt = fwd_b_r ? fwd_val_r : (vld_b_r ? rd_b_r : 32'd0);

  msx_alu u_alu (
    .instr (s1_instr_r),
    .vs    (vs),
    .vt    (vt),
    .res   (alu_res)
  );

  assign op     = s1_instr_r[31:26];
  assign halted = (pc_r >= DEPTH_PC);
  assign wr_en  = s1_adv && !halted && alu_res.wr;
  assign is_br  = (op == msx_pkg::OP_BEQ) || (op == msx_pkg::OP_BNE);
  assign take   = (op == msx_pkg::OP_BEQ) ? (vs == vt) : (vs != vt);
  // negative targets wrap high and fail the compare below as well
  assign tgt    = TGT_W'(pc_r) + {{(TGT_W-16){s1_instr_r[15]}}, s1_instr_r[15:0]};

  always_comb begin
    pc_nxt = pc_r + PC_W'(1);
    ev     = msx_pkg::EV_NONE;
    ev_val = 32'd0;
    if (halted) begin
      pc_nxt = DEPTH_PC;
    end else if (is_br) begin
      if (take) begin
        if (tgt >= DEPTH_TGT) begin
          ev     = msx_pkg::EV_BAD_BRANCH;
          pc_nxt = DEPTH_PC;
        end else begin
          pc_nxt = tgt[PC_W-1:0];
        end
      end
    end else if (s1_instr_r == msx_pkg::SYSCALL_WORD) begin
      if (vs == msx_pkg::SYS_PRINT_INT) begin
        ev     = msx_pkg::EV_PRINT_INT;
        ev_val = vt;
      end else if (vs == msx_pkg::SYS_EXIT) begin
        ev     = msx_pkg::EV_EXIT;
        pc_nxt = DEPTH_PC;
      end else if (vs == msx_pkg::SYS_PRINT_CHAR) begin
        ev     = msx_pkg::EV_PRINT_CHAR;
        ev_val = {24'd0, vt[7:0]};
      end else begin
        ev     = msx_pkg::EV_BAD_SYSCALL;
        ev_val = vs;
        pc_nxt = DEPTH_PC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_next_index_r  <= 11'(pc_nxt);
      out_event_res_r   <= ev;
      out_event_value_r <= ev_val;
      out_write_valid_r <= !halted && alu_res.wr;
      out_write_reg_r   <= halted ? 5'd0 : alu_res.dst;
      out_write_value_r <= halted ? 32'd0 : alu_res.val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_index  = out_next_index_r;
  assign out_event_res   = out_event_res_r;
  assign out_event_value = out_event_value_r;
  assign out_write_valid = out_write_valid_r;
  assign out_write_reg   = out_write_reg_r;
  assign out_write_value = out_write_value_r;

  a_pc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= DEPTH_PC)
    else $error("program index beyond depth");

  a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> alu_res.dst != 5'd0)
    else $error("write to register zero");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (ev == msx_pkg::EV_EXIT || ev == msx_pkg::EV_BAD_SYSCALL ||
               ev == msx_pkg::EV_BAD_BRANCH) |=> pc_r == DEPTH_PC)
    else $error("halt event did not halt");

  a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid)
    else $error("executed item not presented");

endmodule
